// File: hw/rtl/mm2_pkg.sv
// Shared types, constants and helpers for the streaming MurmurHash2 block.
package mm2_pkg;

	localparam int HASH_W = 32;
	localparam int CNT_W  = $clog2(HASH_W);

	localparam logic [HASH_W-1:0] MURMUR_M   = 32'h5bd1e995;
	localparam logic [HASH_W-1:0] SEED_RESET = 32'hDEADBEEF;

	localparam int SHIFT_R  = 24;
	localparam int SHIFT_F1 = 13;
	localparam int SHIFT_F2 = 15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MK1,
		ST_MK2,
		ST_MH,
		ST_MT,
		ST_MF,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] product;
	} mul_res_t;

	// Keep the low bytes of a short last word.
	function automatic logic [HASH_W-1:0] tail_mask(input logic [1:0] cnt);
		logic [HASH_W-1:0] m;
		m = '0;
		unique case (cnt)
			2'd1:    m = 32'h0000_00FF;
			2'd2:    m = 32'h0000_FFFF;
			2'd3:    m = 32'h00FF_FFFF;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// File: hw/rtl/murmurhash2_32_stream.sv
// Top level: streaming 32-bit MurmurHash2 with a bit-serial constant multiplier.
//
// Words of a message come in on the slave stream, last word flagged by s_tlast.
// Every multiply by the MurmurHash2 constant runs through one shared shift-add
// unit that takes one operand bit per cycle. A non-last word needs three
// multiplies; a full last word needs four, a short last word two, an empty last
// word one. The hash is held in an output register, so a finished result can
// wait on m_tready while the next message starts. The seed may be written at
// any time and applies from the next message start.
module murmurhash2_32_stream import mm2_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // data_word[31:0], total_length[63:32]
	input  logic [2:0]  s_tuser,   // byte_count[2:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // hash_value[31:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [HASH_W-1:0] seed_q;
	logic [HASH_W-1:0] acc_q;
	logic              in_msg_q;
	logic [HASH_W-1:0] h_q;
	logic [HASH_W-1:0] k_q;
	logic              last_q;
	logic              m_tvalid_q;
	logic [HASH_W-1:0] m_tdata_q;

	logic              mul_start;
	logic [HASH_W-1:0] mul_op;
	mul_res_t          mul_res;

	logic              s_acc;
	logic              full_word;
	logic [HASH_W-1:0] word;
	logic [HASH_W-1:0] h0;
	logic [HASH_W-1:0] h_tail;
	logic [HASH_W-1:0] p;
	logic [HASH_W-1:0] h_fold;
	logic              out_free;

	assign word      = s_tdata[31:0];
	assign s_acc     = s_tvalid && s_tready;
	assign full_word = !s_tlast || s_tuser[2];
	assign h0        = in_msg_q ? acc_q : (seed_q ^ s_tdata[63:32]);
	assign h_tail    = h0 ^ (word & tail_mask(s_tuser[1:0]));
	assign p         = mul_res.product;
	assign h_fold    = p ^ k_q;
	assign out_free  = !m_tvalid_q || m_tready;

	mm2_smul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (mul_op),
		.res     (mul_res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (full_word) begin
						state_d = ST_MK1;
					end else if (s_tuser[1:0] != 2'd0) begin
						state_d = ST_MT;
					end else begin
						state_d = ST_MF;
					end
				end
			end
			ST_MK1: if (mul_res.done) state_d = ST_MK2;
			ST_MK2: if (mul_res.done) state_d = ST_MH;
			ST_MH: begin
				if (mul_res.done) state_d = last_q ? ST_MF : ST_IDLE;
			end
			ST_MT:  if (mul_res.done) state_d = ST_MF;
			ST_MF:  if (mul_res.done) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and multiplier requests
	always_comb begin
		s_tready  = 1'b0;
		mul_start = 1'b0;
		mul_op    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				mul_start = s_acc;
				if (full_word) begin
					mul_op = word;
				end else if (s_tuser[1:0] != 2'd0) begin
					mul_op = h_tail;
				end else begin
					mul_op = h0 ^ (h0 >> SHIFT_F1);
				end
			end
			ST_MK1: begin
				mul_start = mul_res.done;
				mul_op    = p ^ (p >> SHIFT_R);
			end
			ST_MK2: begin
				mul_start = mul_res.done;
				mul_op    = h_q;
			end
			ST_MH: begin
				mul_start = mul_res.done && last_q;
				mul_op    = h_fold ^ (h_fold >> SHIFT_F1);
			end
			ST_MT: begin
				mul_start = mul_res.done;
				mul_op    = p ^ (p >> SHIFT_F1);
			end
			ST_MF, ST_EMIT: begin
				mul_start = 1'b0;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seed_q     <= SEED_RESET;
			acc_q      <= '0;
			in_msg_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				seed_q <= cfg_data;
			end
			if (s_acc) begin
				in_msg_q <= !s_tlast;
			end
			if (state_q == ST_MH && mul_res.done && !last_q) begin
				acc_q <= h_fold;
			end
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			h_q    <= h0;
			last_q <= s_tlast;
		end
		if (state_q == ST_MK2 && mul_res.done) begin
			k_q <= p;
		end
		if (state_q == ST_MF && mul_res.done) begin
			h_q <= p ^ (p >> SHIFT_F2);
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= h_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

endmodule

// File: hw/rtl/mm2_smul.sv
// Bit-serial shift-add multiplier by the MurmurHash2 constant, modulo 2^32.
module mm2_smul import mm2_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] operand,
	output mul_res_t          res
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] a_q;
	logic [HASH_W-1:0] m_q;
	logic [HASH_W-1:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One operand bit per cycle; the constant walks left as the operand walks right.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= operand;
			m_q    <= MURMUR_M;
			prod_q <= '0;
		end else if (busy_q) begin
			if (a_q[0]) begin
				prod_q <= prod_q + m_q;
			end
			a_q <= a_q >> 1;
			m_q <= m_q << 1;
		end
	end

	assign res.done    = done_q;
	assign res.product = prod_q;

endmodule
